/* rtl/bphq_pkg.sv */
package bphq_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int NOW_W      = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK    = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [CFG_W-1:0] HOLD_RST     = 16'd75;
  localparam logic [CFG_W-1:0] STUCK_RST    = 16'd2000;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] stuck_ms;
  } cfg_t;

  typedef struct packed {
    logic toggle_state;
    logic press_event;
    logic held_flag;
    logic stuck_flag;
    logic press_latched;
  } res_t;

endpackage

/* rtl/bphq_cfg_regs.sv */
module bphq_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [bphq_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [bphq_pkg::CFG_W-1:0]         wr_data,
  output bphq_pkg::cfg_t                     cfg
);
  import bphq_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_DEBOUNCE: cfg_nxt.debounce_ms = wr_data;
        CFG_HOLD:     cfg_nxt.hold_ms     = wr_data;
        CFG_STUCK:    cfg_nxt.stuck_ms    = wr_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms <= DEBOUNCE_RST;
      cfg_r.hold_ms     <= HOLD_RST;
      cfg_r.stuck_ms    <= STUCK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/bphq_core.sv */
module bphq_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                pin_level,
  input  logic [bphq_pkg::TIME_WIDTH-1:0]     now,
  input  bphq_pkg::cfg_t                      cfg,
  output bphq_pkg::res_t                      res
);
  import bphq_pkg::*;

  logic                  latch_r,  latch_nxt;
  logic [TIME_WIDTH-1:0] edge_r,   edge_nxt;
  logic                  toggle_r, toggle_nxt;
  logic                  hold_r,   hold_nxt;
  logic                  stuck_r,  stuck_nxt;

  logic                  pressed;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  over_deb, over_hold, over_stuck;
  logic                  press_acc, rel_acc, hold_hit, stuck_hit;

  // wrapping elapsed time
  assign pressed    = !pin_level;
  assign elapsed    = now - edge_r;
  assign over_deb   = elapsed > TIME_WIDTH'(cfg.debounce_ms);
  assign over_hold  = elapsed > TIME_WIDTH'(cfg.hold_ms);
  assign over_stuck = elapsed > TIME_WIDTH'(cfg.stuck_ms);

  // a latched press can't be re-accepted, so hold/stuck see the old edge
  assign press_acc = pressed && !latch_r && over_deb;
  assign rel_acc   = !pressed && over_deb;
  assign hold_hit  = pressed && latch_r && over_hold && !over_stuck;
  assign stuck_hit = pressed && latch_r && over_stuck;

  always_comb begin
    latch_nxt  = latch_r;
    edge_nxt   = edge_r;
    hold_nxt   = hold_r;
    stuck_nxt  = stuck_r;
    toggle_nxt = toggle_r ^ (press_acc | hold_hit | stuck_hit);
    if (press_acc) begin
      latch_nxt = 1'b1;
      edge_nxt  = now;
    end
    if (rel_acc) begin
      latch_nxt = 1'b0;
      hold_nxt  = 1'b0;
      stuck_nxt = 1'b0;
      edge_nxt  = now;
    end
    if (hold_hit) begin
      hold_nxt = 1'b1;
    end
    if (stuck_hit) begin
      hold_nxt  = 1'b0;
      stuck_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r  <= 1'b0;
      edge_r   <= '0;
      toggle_r <= 1'b0;
      hold_r   <= 1'b0;
      stuck_r  <= 1'b0;
    end else if (adv) begin
      latch_r  <= latch_nxt;
      edge_r   <= edge_nxt;
      toggle_r <= toggle_nxt;
      hold_r   <= hold_nxt;
      stuck_r  <= stuck_nxt;
    end
  end

  assign res.toggle_state  = toggle_nxt;
  assign res.press_event   = press_acc;
  assign res.held_flag     = hold_nxt;
  assign res.stuck_flag    = stuck_nxt;
  assign res.press_latched = latch_nxt;

  a_event_latches: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && press_acc) |-> latch_nxt)
    else $error("press event without latch");

  a_press_updates: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && press_acc) |=> (latch_r && edge_r == $past(now)))
    else $error("accepted press did not latch edge");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && rel_acc) |=> (!latch_r && !hold_r && !stuck_r))
    else $error("accepted release did not clear flags");

endmodule

/* rtl/button_press_hold_qualifier.sv */
// An accepted input beat reaches its result beat through the input register,
// then the result register. Throughput: one poll per cycle while results are
// not stalled; the state update is a single 32-bit subtract plus three
// compares between the input and result registers.
// Reset (rst_n low, synchronous): state flags and edge time cleared,
// registers back to debounce 30, hold 75, stuck 2000 ms; no beat pending.
module button_press_hold_qualifier (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_pin_level,
  input  logic [31:0]                      in_now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_toggle_state,
  output logic                             out_press_event,
  output logic                             out_held_flag,
  output logic                             out_stuck_flag,
  output logic                             out_press_latched,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bphq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                      cfg_data
);
  import bphq_pkg::*;

  cfg_t                  cfg;
  res_t                  res;
  res_t                  res_r;
  logic                  out_valid_r;
  logic                  s1_valid_r;
  logic                  s1_pin_r;
  logic [TIME_WIDTH-1:0] s1_now_r;
  logic                  out_open;
  logic                  adv;
  logic                  in_fire;

  assign cfg_ready = 1'b1;
  assign out_open  = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_open;
  assign in_stall  = s1_valid_r && !out_open;
  assign in_fire   = in_valid && !in_stall;

  bphq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bphq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .pin_level (s1_pin_r),
    .now       (s1_now_r),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pin_r <= in_pin_level;
      s1_now_r <= in_now_ms[TIME_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_open) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_toggle_state  = res_r.toggle_state;
  assign out_press_event   = res_r.press_event;
  assign out_held_flag     = res_r.held_flag;
  assign out_stuck_flag    = res_r.stuck_flag;
  assign out_press_latched = res_r.press_latched;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import bphq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_POLLS = 126;
  localparam int PHASES = 7;

  typedef struct packed {
    logic        pin;
    logic [31:0] now;
    res_t        want;
  } poll_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_pin_level = 1'b1;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_toggle_state;
  logic out_press_event;
  logic out_held_flag;
  logic out_stuck_flag;
  logic out_press_latched;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DEBOUNCE;
  logic [15:0] cfg_data = '0;

  // tags that travel with the input beat
  logic beat_typed = 1'b0;
  res_t beat_want = '0;

  button_press_hold_qualifier dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pin_level      (in_pin_level),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_toggle_state  (out_toggle_state),
    .out_press_event   (out_press_event),
    .out_held_flag     (out_held_flag),
    .out_stuck_flag    (out_stuck_flag),
    .out_press_latched (out_press_latched),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // qualifier state as seen by the checker
  logic [CFG_W-1:0] deb_set, hold_set, stuck_set;
  logic             latched_q, toggle_q, held_q, stuck_q;
  logic [31:0]      edge_ms;

  res_t  due_results[$];
  int    mismatches = 0;
  int    cycles = 0;
  int    burst_left = 1;
  string field_name[5] = '{"toggle_state", "press_event", "held_flag", "stuck_flag",
                           "press_latched"};

  task automatic note_error(input string msg);
    if (mismatches < 40) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic res_t qualify_poll(input logic pin, input logic [31:0] now);
    logic        pressed;
    logic        pulse;
    logic [31:0] since;
    res_t        r;
    pressed = !pin;
    pulse = 1'b0;
    since = now - edge_ms;
    if (pressed && !latched_q && since > deb_set) begin
      toggle_q = ~toggle_q;
      latched_q = 1'b1;
      edge_ms = now;
      pulse = 1'b1;
    end
    since = now - edge_ms;
    if (!pressed && since > deb_set) begin
      latched_q = 1'b0;
      held_q = 1'b0;
      stuck_q = 1'b0;
      edge_ms = now;
    end
    since = now - edge_ms;
    if (pressed && latched_q && since > hold_set && since <= stuck_set) begin
      held_q = 1'b1;
      toggle_q = ~toggle_q;
    end
    if (pressed && latched_q && since > stuck_set) begin
      held_q = 1'b0;
      stuck_q = 1'b1;
      toggle_q = ~toggle_q;
    end
    r.toggle_state = toggle_q;
    r.press_event = pulse;
    r.held_flag = held_q;
    r.stuck_flag = stuck_q;
    r.press_latched = latched_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t got;
    res_t want;
    res_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_toggle_state, out_press_event, out_held_flag, out_stuck_flag,
               out_press_latched};
        if (due_results.size() == 0) begin
          note_error($sformatf("result beat %b with no poll waiting", got));
        end else begin
          want = due_results.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (got[4-i] !== want[4-i]) begin
              note_error($sformatf("%s got %b want %b", field_name[i], got[4-i],
                                   want[4-i]));
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        pred = qualify_poll(in_pin_level, in_now_ms);
        due_results.push_back(beat_typed ? beat_want : pred);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEBOUNCE: deb_set = cfg_data;
          CFG_HOLD:     hold_set = cfg_data;
          CFG_STUCK:    stuck_set = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("button_press_hold_qualifier regression: fail");
      $finish;
    end
  end

  // result side back-pressure, pattern changes every stretch
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_poll(input logic pin, input logic [31:0] now, input logic typed,
                           input res_t want);
    in_valid <= 1'b1;
    in_pin_level <= pin;
    in_now_ms <= now;
    beat_typed <= typed;
    beat_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 120) :
                   $urandom_range(1, 30);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // want bits: toggle, event, held, stuck, latched
  poll_row_t polls_dir[16] = '{
    '{1'b0, 32'd10,         5'b00000},
    '{1'b0, 32'd30,         5'b00000},
    '{1'b0, 32'd31,         5'b11001},
    '{1'b0, 32'd106,        5'b10001},
    '{1'b0, 32'd107,        5'b00101},
    '{1'b0, 32'd2031,       5'b10101},
    '{1'b0, 32'd2032,       5'b00011},
    '{1'b1, 32'd2040,       5'b00000},
    '{1'b0, 32'd2050,       5'b00000},
    '{1'b1, 32'd2060,       5'b00000},
    '{1'b0, 32'd2071,       5'b11001},
    '{1'b1, 32'd2080,       5'b10001},
    '{1'b0, 32'd5,          5'b00011},
    '{1'b1, 32'hFFFF_FFFF,  5'b00000},
    '{1'b0, 32'h0000_001F,  5'b11001},
    '{1'b1, 32'h0000_003E,  5'b10000}
  };

  cfg_t        phase_set[PHASES];
  logic [31:0] clock_ms;
  logic        button_down;
  int          hold_polls;
  int          span;
  logic        pin;

  initial begin
    deb_set = DEBOUNCE_RST;
    hold_set = HOLD_RST;
    stuck_set = STUCK_RST;
    latched_q = 1'b0;
    toggle_q = 1'b0;
    held_q = 1'b0;
    stuck_q = 1'b0;
    edge_ms = '0;

    phase_set[0] = {DEBOUNCE_RST, HOLD_RST, STUCK_RST};
    phase_set[1] = {16'd0, 16'd0, 16'd0};
    phase_set[2] = {16'hFFFF, 16'hFFFF, 16'hFFFF};
    phase_set[3] = {16'd5, 16'd20, 16'd100};
    phase_set[4] = {16'd10, 16'd200, 16'd50};
    phase_set[5] = {16'd100, 16'd1000, 16'hFFFF};
    phase_set[6] = {16'($urandom_range(0, 60)), 16'($urandom_range(0, 400)),
                    16'($urandom_range(0, 800))};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (polls_dir[i]) begin
      send_poll(polls_dir[i].pin, polls_dir[i].now, 1'b1, polls_dir[i].want);
    end
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        write_reg(CFG_DEBOUNCE, phase_set[p].debounce_ms);
        write_reg(CFG_HOLD, phase_set[p].hold_ms);
        if (p % 2 == 0) begin
          write_reg(CFG_UNUSED, 16'($urandom));
        end
        write_reg(CFG_STUCK, phase_set[p].stuck_ms);
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
      clock_ms = $urandom;
      button_down = 1'b0;
      hold_polls = 0;
      for (int n = 0; n < RAND_POLLS; n++) begin
        if ($urandom_range(0, 99) < 12) begin
          // noise: arbitrary time jump and pin
          pin = 1'($urandom_range(0, 1));
          clock_ms = $urandom;
        end else begin
          if (hold_polls == 0) begin
            button_down = ~button_down;
            hold_polls = $urandom_range(1, 40);
          end
          hold_polls--;
          case ($urandom_range(0, 2))
            0:       span = phase_set[p].debounce_ms / 4;
            1:       span = phase_set[p].hold_ms / 4;
            default: span = phase_set[p].stuck_ms / 8;
          endcase
          clock_ms = clock_ms + $urandom_range(0, span + 2);
          pin = !button_down;
          if ($urandom_range(0, 9) == 0) begin
            pin = ~pin;
          end
        end
        send_poll(pin, clock_ms, 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("button_press_hold_qualifier regression: pass");
    end else begin
      $display("button_press_hold_qualifier regression: fail");
    end
    $finish;
  end

endmodule
